// ----- src/pct_pkg.sv -----
// Shared types and constants of the peer contact table.
package pct_pkg;

	localparam int PEER_W = 16;
	localparam int FLAG_W = 8;
	localparam int DAY_W = 27;
	localparam int SLOT_W = 4;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// One command transaction.
	typedef struct packed {
		logic kind;
		logic [PEER_W-1:0] peer_id;
		logic [FLAG_W-1:0] flag_bits;
		logic [DAY_W-1:0] day_key;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic greet;
		logic found;
		logic [SLOT_W-1:0] slot;
		logic evicted;
		logic [FLAG_W-1:0] merged_flags;
	} res_t;

	// One table entry as stored in the memory.
	typedef struct packed {
		logic [PEER_W-1:0] peer;
		logic [FLAG_W-1:0] flags;
		logic [DAY_W-1:0] day;
	} entry_t;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic clear;
		logic valid;
	} scan_ctl_t;

	// Match status from the scan unit.
	typedef struct packed {
		logic hit;
		entry_t hit_entry;
	} scan_stat_t;

endpackage

// ----- src/pct_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module pct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/pct_scan.sv -----
// Scan unit: finds the first matching peer and the oldest entry over a read stream.
module pct_scan import pct_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  scan_ctl_t                  ctl,
	input  logic [PEER_W-1:0]          key,
	input  entry_t                     rd_entry,
	output scan_stat_t                 stat,
	output logic [$clog2(ENTRIES)-1:0] hit_idx,
	output logic [$clog2(ENTRIES)-1:0] min_idx
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic [IDX_W-1:0] cnt_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           hit_entry_q;
	logic [IDX_W-1:0] min_idx_q;
	logic [DAY_W-1:0] min_day_q;

	logic match;
	logic older;

	// First match only; strict less-than keeps the lowest index on equal days
	assign match = !hit_q && (rd_entry.peer == key);
	assign older = (cnt_q == '0) || (rd_entry.day < min_day_q);

	// Track index of the entry now on the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			cnt_q <= '0;
			hit_q <= 1'b0;
		end else if (ctl.valid) begin
			cnt_q <= cnt_q + 1'b1;
			if (match) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Capture matched entry and running minimum
	always_ff @(posedge clk) begin
		if (ctl.valid && !ctl.clear) begin
			if (match) begin
				hit_idx_q   <= cnt_q;
				hit_entry_q <= rd_entry;
			end
			if (older) begin
				min_idx_q <= cnt_q;
				min_day_q <= rd_entry.day;
			end
		end
	end

	assign stat.hit       = hit_q;
	assign stat.hit_entry = hit_entry_q;
	assign hit_idx        = hit_idx_q;
	assign min_idx        = min_idx_q;

endmodule

// ----- src/peer_contact_table_top.sv -----
// Top level of the peer contact table: sequencer, fill count, entry memory and scan unit.
//
// A command is taken when start is high and busy is low. The block then reads every
// filled entry through the single read port of its entry memory, one entry a cycle,
// then decides once the registered read data has passed the scan unit; the result
// shows on result for one cycle with done high, and the receiver cannot hold it off.
// busy stays high through the scan, drain and decide states (only the decide state
// while the table is empty), so the sweep over the filled entries sets how long busy
// stays high; done is registered from the decide state.
// A new command may be taken in the cycle that shows the previous result.
module peer_contact_table_top import pct_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output res_t result
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int ENT_W = $bits(entry_t);
	localparam int SW = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  addr_q;
	logic              rd_valid_s1;
	logic              done_q;
	res_t              res_q;

	logic              accept;
	logic              rd_en;
	logic              last_rd;
	logic              full;
	scan_ctl_t         scan_ctl;
	scan_stat_t        scan_stat;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  min_idx;
	logic [ENT_W-1:0]  rd_word;
	entry_t            rd_entry;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	entry_t            wr_entry;
	logic              fill_inc;
	res_t              res_d;
	logic [SW-1:0]     slot_wide;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign rd_en    = (state_q == S_SCAN);
	assign last_rd  = (FILL_W'(addr_q) + 1'b1) == fill_q;
	assign full     = (fill_q == FILL_W'(ENTRIES));
	assign rd_entry = entry_t'(rd_word);

	assign scan_ctl.clear = accept;
	assign scan_ctl.valid = rd_valid_s1;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					if (start) begin
						state_q <= (fill_q == '0) ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (last_rd) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the command for the whole transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// Decide: pick the entry, build the write-back and the result
	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = '0;
		fill_inc  = 1'b0;
		res_d     = '0;
		wr_entry.peer  = cmd_q.peer_id;
		wr_entry.flags = cmd_q.flag_bits;
		wr_entry.day   = cmd_q.day_key;
		res_d.found = scan_stat.hit;
		if (cmd_q.kind == KIND_RECORD) begin
			if (scan_stat.hit) begin
				wr_idx         = hit_idx;
				wr_entry.flags = scan_stat.hit_entry.flags | cmd_q.flag_bits;
			end else if (!full) begin
				wr_idx   = fill_q[IDX_W-1:0];
				fill_inc = 1'b1;
			end else begin
				wr_idx        = min_idx;
				res_d.evicted = 1'b1;
			end
			wr_en              = (state_q == S_DECIDE);
			res_d.merged_flags = wr_entry.flags;
		end else begin
			if (scan_stat.hit) begin
				wr_idx             = hit_idx;
				res_d.greet        = (scan_stat.hit_entry.day != cmd_q.day_key);
				res_d.merged_flags = scan_stat.hit_entry.flags;
			end else begin
				res_d.greet = 1'b1;
			end
		end
		slot_wide  = SW'(wr_idx);
		res_d.slot = (cmd_q.kind == KIND_QUERY && !scan_stat.hit) ? '0 : slot_wide[SLOT_W-1:0];
	end

	// Fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == S_DECIDE);
			if (wr_en && fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	pct_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx),
		.wr_data(ENT_W'(wr_entry)),
		.rd_en  (rd_en),
		.rd_addr(addr_q),
		.rd_data(rd_word)
	);

	pct_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.key     (cmd_q.peer_id),
		.rd_entry(rd_entry),
		.stat    (scan_stat),
		.hit_idx (hit_idx),
		.min_idx (min_idx)
	);

	// Fill count never passes the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(ENTRIES))
		else $error("fill count above table size");

	// A result follows only a decide cycle
	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_DECIDE))
		else $error("result strobe without decide");

	// An accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start");

	// The table is written only by a record in its decide cycle
	a_write_record: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_DECIDE) && (cmd_q.kind == KIND_RECORD))
		else $error("table write outside a record decide");

	// Reads never run past the filled entries
	a_read_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (FILL_W'(addr_q) < fill_q))
		else $error("read beyond filled entries");

endmodule
